// ----- design/fphs_pkg.sv -----
// Shared types and constants for the framed H.264 parameter-set splitter.
// Depends on nothing; every other design file imports it.
package fphs_pkg;

    // Package header layout
    localparam int HEADER_BYTES = 32;
    localparam int WIN_BYTES    = 5;
    localparam int MAX_RES      = 6;

    // Header word positions (32-bit words, little endian)
    localparam logic [2:0] HW_FLAG   = 3'd2;
    localparam logic [2:0] HW_FORMAT = 3'd4;
    localparam logic [2:0] HW_WIDTH  = 3'd5;
    localparam logic [2:0] HW_HEIGHT = 3'd6;
    localparam logic [2:0] HW_SIZE   = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_PARAM  = 2'd0;
    localparam logic [1:0] KIND_VIDEO  = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] KIND_BROKEN = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_FORMAT      = 2'd0;
    localparam logic [1:0] CFG_FLAG        = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

    localparam logic [31:0] RST_FORMAT      = 32'd7;
    localparam logic [31:0] RST_FLAG        = 32'd2;
    localparam logic [22:0] RST_MAX_PAYLOAD = 23'h400000;

    // Input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
        logic       abort;
    } src_t;

    // Output request
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  kind;
        logic        unit_last;
        logic [31:0] frame_width;
        logic [31:0] frame_height;
    } res_t;

    // Configuration seen by the parser
    typedef struct packed {
        logic [31:0] accepted_format;
        logic [31:0] expected_flag;
        logic [22:0] max_payload;
    } cfg_t;

    // One result slot inside a bundle
    typedef struct packed {
        logic [7:0] ent_byte;
        logic [1:0] ent_kind;
        logic       ent_last;
    } ent_t;

    // All results caused by one input byte
    typedef struct packed {
        logic [2:0]               count;
        ent_t [MAX_RES-1:0]       ent;
        logic [31:0]              width;
        logic [31:0]              height;
    } bundle_t;

endpackage

// ----- design/framed_h264_param_set_splitter_core.sv -----
// Registers on the result path: bundle queue, current-bundle register, output register.
// Throughput: one input byte per cycle unless the queue is full; results leave at one
// per cycle unless res_stall is high, so a byte releasing six results holds the output
// while the bundle queue (QUEUE_DEPTH bundles) keeps taking input until it fills.
// Reset: rst_n clears parser, queue and output state; configuration returns to defaults.
module framed_h264_param_set_splitter_core
    import fphs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  src_t        src_data,
    output logic        res_valid,
    input  logic        res_stall,
    output res_t        res_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    q_full;
    logic    push;
    bundle_t push_data;
    logic    pop;
    bundle_t head;
    logic    head_valid;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accepted_format <= RST_FORMAT;
            cfg_reg.expected_flag   <= RST_FLAG;
            cfg_reg.max_payload     <= RST_MAX_PAYLOAD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FORMAT:      cfg_reg.accepted_format <= cfg_data;
                CFG_FLAG:        cfg_reg.expected_flag   <= cfg_data;
                CFG_MAX_PAYLOAD: cfg_reg.max_payload     <= cfg_data[22:0];
                default:         ;
            endcase
        end
    end

    fphs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_data  (src_data),
        .src_stall (src_stall),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    fphs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    fphs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule

// ----- design/fphs_front.sv -----
// Front end: header parse, payload classification and the five-byte window.
// Emits at most one bundle of up to six results per byte. Depends on fphs_pkg.
module fphs_front
    import fphs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    src_valid,
    input  src_t    src_data,
    output logic    src_stall,
    input  cfg_t    cfg,
    input  logic    q_full,
    output logic    push,
    output bundle_t push_data
);

    typedef enum logic [1:0] {
        MODE_UNDEC = 2'd0,
        MODE_PARAM = 2'd1,
        MODE_VIDEO = 2'd2,
        MODE_DROP  = 2'd3
    } mode_t;

    logic [5:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] flag_reg, flag_next;
    logic [31:0] fmt_reg, fmt_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [31:0] size_reg, size_next;
    logic [22:0] pay_cnt_reg, pay_cnt_next;
    logic [7:0]  win_reg [WIN_BYTES];
    logic [7:0]  win_next [WIN_BYTES];
    logic [2:0]  fill_reg, fill_next;
    mode_t       mode_reg, mode_next;
    logic        discard_reg, discard_next;

    logic        accept;
    bundle_t     bnd;
    logic [7:0]  b;
    logic        pend;
    logic [4:0]  idx;
    logic [7:0]  sh [WIN_BYTES];

    function automatic logic is_start(input logic [7:0] a, input logic [7:0] c,
                                      input logic [7:0] d, input logic [7:0] e);
        return (a == 8'h00) && (c == 8'h00) && (d == 8'h00) && (e == 8'h01);
    endfunction

    function automatic logic is_ps(input logic [7:0] t);
        return (t[4:0] == 5'd7) || (t[4:0] == 5'd8);
    endfunction

    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;
    assign b         = src_data.data_byte;
    assign idx       = hdr_cnt_reg[4:0];
    assign push      = accept && (bnd.count != 3'd0);
    assign push_data = bnd;

    // Per-byte parse and classification
    always_comb
    begin
        hdr_cnt_next = hdr_cnt_reg;
        flag_next    = flag_reg;
        fmt_next     = fmt_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        size_next    = size_reg;
        pay_cnt_next = pay_cnt_reg;
        win_next     = win_reg;
        fill_next    = fill_reg;
        mode_next    = mode_reg;
        discard_next = discard_reg;
        bnd          = '0;
        pend         = 1'b0;
        for (int i = 0; i < WIN_BYTES; i++)
        begin
            sh[i] = 8'h00;
        end

        if (src_data.abort)
        begin
            hdr_cnt_next = '0;
            flag_next    = '0;
            fmt_next     = '0;
            width_next   = '0;
            height_next  = '0;
            size_next    = '0;
            pay_cnt_next = '0;
            for (int i = 0; i < WIN_BYTES; i++)
            begin
                win_next[i] = 8'h00;
            end
            fill_next    = '0;
            mode_next    = MODE_UNDEC;
            discard_next = 1'b0;
        end
        else if (discard_reg)
        begin
            if (src_data.chunk_end)
            begin
                discard_next = 1'b0;
            end
        end
        else if (hdr_cnt_reg < 6'(HEADER_BYTES))
        begin
            // Header byte: gather little-endian words
            if (idx == 5'd0)
            begin
                flag_next   = '0;
                fmt_next    = '0;
                width_next  = '0;
                height_next = '0;
                size_next   = '0;
            end
            case (idx[4:2])
                HW_FLAG:   flag_next[{idx[1:0], 3'b000} +: 8]   = b;
                HW_FORMAT: fmt_next[{idx[1:0], 3'b000} +: 8]    = b;
                HW_WIDTH:  width_next[{idx[1:0], 3'b000} +: 8]  = b;
                HW_HEIGHT: height_next[{idx[1:0], 3'b000} +: 8] = b;
                HW_SIZE:   size_next[{idx[1:0], 3'b000} +: 8]   = b;
                default:   ;
            endcase
            hdr_cnt_next = hdr_cnt_reg + 6'd1;
            if (hdr_cnt_next == 6'(HEADER_BYTES))
            begin
                if ((flag_next != cfg.expected_flag) ||
                    (size_next > {9'd0, cfg.max_payload}))
                begin
                    bnd.count  = 3'd1;
                    bnd.ent[0] = '{ent_byte: 8'h00, ent_kind: KIND_BROKEN, ent_last: 1'b0};
                    hdr_cnt_next = '0;
                    discard_next = !src_data.chunk_end;
                end
                else
                begin
                    pay_cnt_next = '0;
                    fill_next    = '0;
                    mode_next    = (fmt_next == cfg.accepted_format) ? MODE_UNDEC : MODE_DROP;
                    if (size_next == 32'd0)
                    begin
                        if (fmt_next == cfg.accepted_format)
                        begin
                            bnd.count  = 3'd1;
                            bnd.ent[0] = '{ent_byte: 8'h00, ent_kind: KIND_EMPTY,
                                           ent_last: 1'b1};
                        end
                        hdr_cnt_next = '0;
                        mode_next    = MODE_UNDEC;
                    end
                end
            end
        end
        else
        begin
            // Payload byte
            pay_cnt_next = pay_cnt_reg + 23'd1;
            pend         = ({9'd0, pay_cnt_next} >= size_reg);
            case (mode_reg)
                MODE_VIDEO:
                begin
                    bnd.count  = 3'd1;
                    bnd.ent[0] = '{ent_byte: b, ent_kind: KIND_VIDEO, ent_last: pend};
                end
                MODE_UNDEC:
                begin
                    win_next[fill_reg] = b;
                    fill_next          = fill_reg + 3'd1;
                    if ((fill_next == 3'(WIN_BYTES)) || pend)
                    begin
                        if ((fill_next == 3'(WIN_BYTES)) && !pend &&
                            is_start(win_next[0], win_next[1], win_next[2], win_next[3]) &&
                            is_ps(win_next[4]))
                        begin
                            mode_next = MODE_PARAM;
                        end
                        else
                        begin
                            // Not a parameter-set lead-in: flush as video
                            bnd.count = fill_next;
                            for (int i = 0; i < WIN_BYTES; i++)
                            begin
                                if (3'(i) < fill_next)
                                begin
                                    bnd.ent[i] = '{ent_byte: win_next[i], ent_kind: KIND_VIDEO,
                                                   ent_last: pend && (3'(i + 1) == fill_next)};
                                end
                            end
                            fill_next = '0;
                            mode_next = MODE_VIDEO;
                        end
                    end
                end
                MODE_PARAM:
                begin
                    if (is_start(win_reg[1], win_reg[2], win_reg[3], win_reg[4]) && !is_ps(b))
                    begin
                        // Start code of a video NAL: close the parameter-set unit
                        bnd.count  = 3'd6;
                        bnd.ent[0] = '{ent_byte: win_reg[0], ent_kind: KIND_PARAM,
                                       ent_last: 1'b1};
                        for (int i = 1; i < WIN_BYTES; i++)
                        begin
                            bnd.ent[i] = '{ent_byte: win_reg[i], ent_kind: KIND_VIDEO,
                                           ent_last: 1'b0};
                        end
                        bnd.ent[5] = '{ent_byte: b, ent_kind: KIND_VIDEO, ent_last: pend};
                        fill_next  = '0;
                        mode_next  = MODE_VIDEO;
                    end
                    else
                    begin
                        // Release oldest byte, shift the new one in
                        bnd.ent[0] = '{ent_byte: win_reg[0], ent_kind: KIND_PARAM,
                                       ent_last: 1'b0};
                        for (int i = 0; i < WIN_BYTES - 1; i++)
                        begin
                            sh[i] = win_reg[i + 1];
                        end
                        sh[WIN_BYTES - 1] = b;
                        win_next = sh;
                        if (pend)
                        begin
                            bnd.count = 3'd6;
                            if (is_start(sh[1], sh[2], sh[3], sh[4]))
                            begin
                                bnd.ent[1] = '{ent_byte: sh[0], ent_kind: KIND_PARAM,
                                               ent_last: 1'b1};
                                for (int i = 1; i < WIN_BYTES; i++)
                                begin
                                    bnd.ent[i + 1] = '{ent_byte: sh[i], ent_kind: KIND_VIDEO,
                                                       ent_last: (i == WIN_BYTES - 1)};
                                end
                            end
                            else
                            begin
                                for (int i = 0; i < WIN_BYTES; i++)
                                begin
                                    bnd.ent[i + 1] = '{ent_byte: sh[i], ent_kind: KIND_PARAM,
                                                       ent_last: (i == WIN_BYTES - 1)};
                                end
                            end
                            fill_next = '0;
                        end
                        else
                        begin
                            bnd.count = 3'd1;
                        end
                    end
                end
                default: ;
            endcase
            if (pend)
            begin
                hdr_cnt_next = '0;
                fill_next    = '0;
                mode_next    = MODE_UNDEC;
            end
        end

        bnd.width  = width_next;
        bnd.height = height_next;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg <= '0;
            flag_reg    <= '0;
            fmt_reg     <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            size_reg    <= '0;
            pay_cnt_reg <= '0;
            for (int i = 0; i < WIN_BYTES; i++)
            begin
                win_reg[i] <= 8'h00;
            end
            fill_reg    <= '0;
            mode_reg    <= MODE_UNDEC;
            discard_reg <= 1'b0;
        end
        else if (accept)
        begin
            hdr_cnt_reg <= hdr_cnt_next;
            flag_reg    <= flag_next;
            fmt_reg     <= fmt_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            size_reg    <= size_next;
            pay_cnt_reg <= pay_cnt_next;
            win_reg     <= win_next;
            fill_reg    <= fill_next;
            mode_reg    <= mode_next;
            discard_reg <= discard_next;
        end
    end

endmodule

// ----- design/fphs_queue.sv -----
// Small bundle queue between the parser and the result serializer.
// Depends on fphs_pkg for the bundle type.
module fphs_queue
    import fphs_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output bundle_t head,
    output logic    head_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t        mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_pop;

    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/fphs_back.sv -----
// Result serializer: walks each bundle and presents one result per cycle while
// res_stall is low, through a registered output stage. Depends on fphs_pkg.
module fphs_back
    import fphs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  bundle_t head,
    input  logic    head_valid,
    output logic    pop,
    output logic    res_valid,
    input  logic    res_stall,
    output res_t    res_data
);

    bundle_t    cur_reg;
    logic       cur_valid_reg;
    logic [2:0] idx_reg;
    logic       res_valid_reg;
    res_t       res_data_reg;

    logic       out_free;
    logic       take;
    logic       last_ent;
    ent_t       sel;

    assign out_free = !res_valid_reg || !res_stall;
    assign take     = cur_valid_reg && out_free;
    assign last_ent = (idx_reg == cur_reg.count - 3'd1);
    assign pop      = head_valid && (!cur_valid_reg || (take && last_ent));
    assign sel      = cur_reg.ent[idx_reg];

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Current bundle and slot index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (take)
        begin
            cur_valid_reg <= !last_ent;
            idx_reg       <= last_ent ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_data_reg.out_byte     <= sel.ent_byte;
            res_data_reg.kind         <= sel.ent_kind;
            res_data_reg.unit_last    <= sel.ent_last;
            res_data_reg.frame_width  <= cur_reg.width;
            res_data_reg.frame_height <= cur_reg.height;
        end
    end

endmodule

// ----- design/fphs_checker.sv -----
// Port-level checks on the splitter's result channel, bound to the top level.
// Depends on fphs_pkg for the result type and kind codes.
module fphs_checker
    import fphs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_stall,
    input res_t res_data
);

    // A stalled result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // Broken package report carries no byte and closes no unit
    a_broken: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.kind == KIND_BROKEN) |->
            (res_data.out_byte == 8'h00) && !res_data.unit_last)
        else $error("malformed broken-package result");

    // Empty video unit is a single closing marker
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.kind == KIND_EMPTY) |->
            (res_data.out_byte == 8'h00) && res_data.unit_last)
        else $error("malformed empty-unit result");

    // Result valid is always a known level out of reset
    a_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(res_valid))
        else $error("result valid unknown");

endmodule

bind framed_h264_param_set_splitter_core fphs_checker u_fphs_checker (.*);
